>>> rtl/lhrm_pkg.sv
// Shared types and constants of the latency histogram and rate monitor.
`timescale 1ns / 1ps
`default_nettype none
package lhrm_pkg;

	// request kinds carried in the input tuser
	localparam logic [1:0] REQ_RECORD   = 2'd0;
	localparam logic [1:0] REQ_SNAPSHOT = 2'd1;
	localparam logic [1:0] REQ_CLEAR    = 2'd2;

	// register indexes (paddr bit 2)
	localparam logic REG_BUCKET_WIDTH = 1'b0;
	localparam logic REG_EMA_ALPHA    = 1'b1;

	localparam logic [19:0] WIDTH_RESET = 20'd1000;
	localparam logic [16:0] ALPHA_RESET = 17'd6554;
	localparam logic [16:0] ALPHA_ONE   = 17'd65536;

	localparam logic [31:0] FPS_SCALE  = 32'd256000000;
	localparam logic [31:0] DROP_SCALE = 32'd65536;
	localparam logic [95:0] ROUND_HALF = 96'd32768;
	localparam logic [22:0] MEAN_MAX   = 23'h7FFFFF;

	// divider step counts
	localparam logic [6:0] REC_STEPS    = 7'd24;
	localparam logic [6:0] MULDIV_STEPS = 7'd32;
	localparam logic [6:0] MEAN_STEPS   = 7'd64;

	typedef enum logic [5:0] {
		ST_CLR_INIT, ST_CLR, ST_IDLE, ST_DISPATCH,
		ST_REC_DIV, ST_REC_WAIT, ST_REC_RD, ST_REC_WR,
		ST_SNP_CHK, ST_SNP_RES,
		ST_AVG_M1, ST_AVG_M2, ST_AVG_M3, ST_AVG_DIV, ST_AVG_WAIT, ST_AVG_INST,
		ST_AVG_B1, ST_AVG_B2, ST_AVG_B3, ST_AVG_B4, ST_AVG_NEXT,
		ST_TGT_M,
		ST_MEAN_DIV, ST_MEAN_WAIT,
		ST_WALK_INIT, ST_WALK_RD, ST_WALK_ACC,
		ST_P95_M, ST_P95, ST_EMIT
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_CLR_INIT, OP_CLR,
		OP_REC_DIV, OP_REC_RD, OP_REC_WR,
		OP_SNP_CHK, OP_SNP_RES,
		OP_AVG_M1, OP_AVG_M2, OP_AVG_M3, OP_AVG_DIV, OP_AVG_INST,
		OP_AVG_B1, OP_AVG_B2, OP_AVG_B3, OP_AVG_B4, OP_AVG_NEXT,
		OP_TGT_M, OP_MEAN_DIV,
		OP_WALK_INIT, OP_WALK_RD, OP_WALK_ACC,
		OP_P95_M, OP_P95, OP_EMIT
	} dp_op_t;

	// status from datapath to controller
	typedef struct packed {
		logic [1:0] req;
		logic       div_busy;
		logic       gate;
		logic       res_nz;
		logic       which;
		logic       have_sel;
		logic       cnt_nz;
		logic       walk_hit;
		logic       clr_last;
		logic       out_free;
	} dp_status_t;

endpackage
`default_nettype wire

>>> rtl/lhrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lhrm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> rtl/lhrm_ctrl.sv
// Sequencer of the monitor: walks each request through its datapath steps.
`timescale 1ns / 1ps
`default_nettype none
module lhrm_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire lhrm_pkg::dp_status_t st,
	output lhrm_pkg::dp_op_t         op
);
	import lhrm_pkg::*;

	state_t state_q, state_n, after_avg;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR_INIT;
		end else begin
			state_q <= state_n;
		end
	end

	// where to go once an average is done
	always_comb begin
		if (!st.which && st.res_nz) begin
			after_avg = ST_AVG_NEXT;
		end else if (st.cnt_nz) begin
			after_avg = ST_TGT_M;
		end else begin
			after_avg = ST_EMIT;
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_CLR_INIT: state_n = ST_CLR;
			ST_CLR:      if (st.clr_last) state_n = ST_IDLE;
			ST_IDLE:     if (s_tvalid) state_n = ST_DISPATCH;
			ST_DISPATCH: begin
				case (st.req)
					REQ_RECORD:   state_n = ST_REC_DIV;
					REQ_SNAPSHOT: state_n = ST_SNP_CHK;
					REQ_CLEAR:    state_n = ST_CLR_INIT;
					default:      state_n = ST_IDLE;
				endcase
			end
			ST_REC_DIV:   state_n = ST_REC_WAIT;
			ST_REC_WAIT:  if (!st.div_busy) state_n = ST_REC_RD;
			ST_REC_RD:    state_n = ST_REC_WR;
			ST_REC_WR:    state_n = ST_IDLE;
			ST_SNP_CHK:   state_n = ST_SNP_RES;
			ST_SNP_RES: begin
				if (st.gate) state_n = ST_AVG_M1;
				else if (st.cnt_nz) state_n = ST_TGT_M;
				else state_n = ST_EMIT;
			end
			ST_AVG_M1:    state_n = ST_AVG_M2;
			ST_AVG_M2:    state_n = ST_AVG_M3;
			ST_AVG_M3:    state_n = ST_AVG_DIV;
			ST_AVG_DIV:   state_n = ST_AVG_WAIT;
			ST_AVG_WAIT:  if (!st.div_busy) state_n = ST_AVG_INST;
			ST_AVG_INST:  state_n = st.have_sel ? ST_AVG_B1 : after_avg;
			ST_AVG_B1:    state_n = ST_AVG_B2;
			ST_AVG_B2:    state_n = ST_AVG_B3;
			ST_AVG_B3:    state_n = ST_AVG_B4;
			ST_AVG_B4:    state_n = after_avg;
			ST_AVG_NEXT:  state_n = ST_AVG_M1;
			ST_TGT_M:     state_n = ST_MEAN_DIV;
			ST_MEAN_DIV:  state_n = ST_MEAN_WAIT;
			ST_MEAN_WAIT: if (!st.div_busy) state_n = ST_WALK_INIT;
			ST_WALK_INIT: state_n = ST_WALK_RD;
			ST_WALK_RD:   state_n = ST_WALK_ACC;
			ST_WALK_ACC:  state_n = st.walk_hit ? ST_P95_M : ST_WALK_RD;
			ST_P95_M:     state_n = ST_P95;
			ST_P95:       state_n = ST_EMIT;
			ST_EMIT:      if (st.out_free) state_n = ST_IDLE;
			default:      state_n = ST_IDLE;
		endcase
	end

	// datapath command per state
	always_comb begin
		s_tready = 1'b0;
		op       = OP_NONE;
		case (state_q)
			ST_CLR_INIT: op = OP_CLR_INIT;
			ST_CLR:      op = OP_CLR;
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) op = OP_LOAD;
			end
			ST_REC_DIV:   op = OP_REC_DIV;
			ST_REC_RD:    op = OP_REC_RD;
			ST_REC_WR:    op = OP_REC_WR;
			ST_SNP_CHK:   op = OP_SNP_CHK;
			ST_SNP_RES:   op = OP_SNP_RES;
			ST_AVG_M1:    op = OP_AVG_M1;
			ST_AVG_M2:    op = OP_AVG_M2;
			ST_AVG_M3:    op = OP_AVG_M3;
			ST_AVG_DIV:   op = OP_AVG_DIV;
			ST_AVG_INST:  op = OP_AVG_INST;
			ST_AVG_B1:    op = OP_AVG_B1;
			ST_AVG_B2:    op = OP_AVG_B2;
			ST_AVG_B3:    op = OP_AVG_B3;
			ST_AVG_B4:    op = OP_AVG_B4;
			ST_AVG_NEXT:  op = OP_AVG_NEXT;
			ST_TGT_M:     op = OP_TGT_M;
			ST_MEAN_DIV:  op = OP_MEAN_DIV;
			ST_WALK_INIT: op = OP_WALK_INIT;
			ST_WALK_RD:   op = OP_WALK_RD;
			ST_WALK_ACC:  op = OP_WALK_ACC;
			ST_P95_M:     op = OP_P95_M;
			ST_P95:       op = OP_P95;
			ST_EMIT:      if (st.out_free) op = OP_EMIT;
			default:      op = OP_NONE;
		endcase
	end
endmodule
`default_nettype wire

>>> rtl/lhrm_dp.sv
// Datapath: statistics registers, histogram RAM, shared multiplier and divider.
`timescale 1ns / 1ps
`default_nettype none
module lhrm_dp #(
	parameter int BUCKETS = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lhrm_pkg::dp_op_t     op,
	output lhrm_pkg::dp_status_t      st,
	input  wire logic [19:0]          bucket_width_us,
	input  wire logic [16:0]          ema_alpha_q16,
	input  wire logic [1:0]           req_type,
	input  wire logic [23:0]          latency_us,
	input  wire logic [63:0]          timestamp_us,
	input  wire logic [63:0]          processed_total,
	input  wire logic [63:0]          drops_total,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output logic [31:0]               fps_q8,
	output logic [16:0]               drop_fraction_q16,
	output logic [22:0]               latency_mean_us,
	output logic [31:0]               latency_p95_us,
	output logic                      latency_valid
);
	import lhrm_pkg::*;

	localparam int BW = $clog2(BUCKETS);
	localparam int CW = 32 + BW;
	localparam logic [BW-1:0] LAST = BW'(BUCKETS - 1);

	// captured word
	logic [1:0]  req_q;
	logic [23:0] lat_q;
	logic [63:0] t_q, proc_q, drops_q;

	// statistics state
	logic [31:0] count_q;
	logic [63:0] sum_q, last_time_q, last_proc_q, last_drops_q;
	logic        have_base_q, have_fps_q, have_drop_q;
	logic [31:0] fps_avg_q;
	logic [16:0] drop_avg_q;

	// working registers
	logic [63:0] dt_q, dp_q, dd_q, res_q;
	logic        gate_q, which_q, sat_q;
	logic [63:0] mul_q;
	logic [95:0] acc_q;
	logic [31:0] inst_q;
	logic [BW-1:0] bin_q, idx_q;
	logic [CW-1:0] cum_q;
	logic [36:0] tgt_q;
	logic [22:0] mean_q;
	logic [31:0] p95_q;

	// divider
	logic [63:0] rem_q, dvd_q, dvs_q;
	logic [6:0]  cnt_q;

	// histogram RAM
	logic          ram_we;
	logic [BW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_wdata, ram_rdata;

	logic [19:0] weff;
	logic [16:0] alpha_eff;
	logic [23:0] lat_clamp;
	logic [63:0] num_sel, den_sel, avg_sel;
	logic [31:0] scale_sel, mul_a, mul_b, inst_raw, inst_n;
	logic        have_sel;
	logic [BW-1:0] bin_n;
	logic [CW-1:0] cum_n;
	logic [CW+4:0] cum_x20;
	logic [36:0] tgt_n;
	logic        walk_hit;
	logic [64:0] sum_ext, div_sh;
	logic        div_ge;
	logic [95:0] blend_sum;
	logic        div_start;
	logic [63:0] rem_ld, dvd_ld, dvs_ld;
	logic [6:0]  cnt_ld;

	assign weff      = (bucket_width_us == 20'd0) ? 20'd1 : bucket_width_us;
	assign alpha_eff = (ema_alpha_q16 > ALPHA_ONE) ? ALPHA_ONE : ema_alpha_q16;
	assign lat_clamp = lat_q[23] ? 24'd0 : lat_q;

	// selection between the fps and drop averages
	assign num_sel   = which_q ? dd_q : dp_q;
	assign den_sel   = which_q ? res_q : dt_q;
	assign scale_sel = which_q ? DROP_SCALE : FPS_SCALE;
	assign avg_sel   = which_q ? {47'd0, drop_avg_q} : {32'd0, fps_avg_q};
	assign have_sel  = which_q ? have_drop_q : have_fps_q;

	// instantaneous value from the quotient
	assign inst_raw = sat_q ? 32'hFFFF_FFFF : dvd_q[31:0];
	assign inst_n   = (which_q && inst_raw > 32'(ALPHA_ONE)) ? 32'(ALPHA_ONE) : inst_raw;
	assign blend_sum = acc_q + ROUND_HALF;

	// percentile test: cum >= ceil(0.95 n) is the same as 20 * cum >= 19 * n
	assign tgt_n   = {1'b0, count_q, 4'd0} + {4'd0, count_q, 1'b0} + {5'd0, count_q};
	assign cum_x20 = {1'b0, cum_n, 4'd0} + {3'd0, cum_n, 2'd0};

	// bin clamp and walk step
	assign bin_n    = (dvd_q[23:0] >= 24'(BUCKETS)) ? LAST : dvd_q[BW-1:0];
	assign cum_n    = cum_q + {{BW{1'b0}}, ram_rdata};
	assign walk_hit = (cum_x20 >= {{(CW-32){1'b0}}, tgt_q}) || (idx_q == LAST);
	assign sum_ext  = {1'b0, sum_q} + {41'd0, lat_clamp};

	// shared multiplier operands
	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (op)
			OP_AVG_M1: begin mul_a = num_sel[31:0];  mul_b = scale_sel; end
			OP_AVG_M2: begin mul_a = num_sel[63:32]; mul_b = scale_sel; end
			OP_AVG_B1: begin mul_a = {15'd0, alpha_eff}; mul_b = inst_q; end
			OP_AVG_B2: begin
				mul_a = {15'd0, ALPHA_ONE - alpha_eff};
				mul_b = avg_sel[31:0];
			end
			OP_P95_M:  begin mul_a = 32'({idx_q, 1'b1}); mul_b = {12'd0, weff}; end
			default:   begin mul_a = 32'd0; mul_b = 32'd0; end
		endcase
	end

	// divider load values
	always_comb begin
		div_start = 1'b1;
		rem_ld    = 64'd0;
		dvd_ld    = 64'd0;
		dvs_ld    = 64'd1;
		cnt_ld    = 7'd0;
		case (op)
			OP_REC_DIV: begin
				dvd_ld = {lat_clamp, 40'd0};
				dvs_ld = {44'd0, weff};
				cnt_ld = REC_STEPS;
			end
			OP_AVG_DIV: begin
				rem_ld = acc_q[95:32];
				dvd_ld = {acc_q[31:0], 32'd0};
				dvs_ld = den_sel;
				cnt_ld = MULDIV_STEPS;
			end
			OP_MEAN_DIV: begin
				dvd_ld = sum_q;
				dvs_ld = {32'd0, count_q};
				cnt_ld = MEAN_STEPS;
			end
			default: div_start = 1'b0;
		endcase
	end

	// restoring divider step, one quotient bit a cycle
	assign div_sh = {rem_q, dvd_q[63]};
	assign div_ge = div_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 7'd0;
		end else if (div_start) begin
			cnt_q <= cnt_ld;
		end else if (cnt_q != 7'd0) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			rem_q <= rem_ld;
			dvd_q <= dvd_ld;
			dvs_q <= dvs_ld;
		end else if (cnt_q != 7'd0) begin
			rem_q <= div_ge ? 64'(div_sh - {1'b0, dvs_q}) : div_sh[63:0];
			dvd_q <= {dvd_q[62:0], div_ge};
		end
	end

	// histogram RAM ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = 32'd0;
		ram_raddr = idx_q;
		case (op)
			OP_CLR:    ram_we = 1'b1;
			OP_REC_RD: ram_raddr = bin_n;
			OP_REC_WR: begin
				ram_we    = 1'b1;
				ram_waddr = bin_q;
				ram_wdata = (ram_rdata == 32'hFFFF_FFFF) ? ram_rdata : ram_rdata + 32'd1;
			end
			default: ram_we = 1'b0;
		endcase
	end

	lhrm_ram #(.WIDTH(32), .DEPTH(BUCKETS)) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// statistics and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= 32'd0;
			sum_q        <= 64'd0;
			last_time_q  <= 64'd0;
			last_proc_q  <= 64'd0;
			last_drops_q <= 64'd0;
			have_base_q  <= 1'b0;
			have_fps_q   <= 1'b0;
			have_drop_q  <= 1'b0;
			fps_avg_q    <= 32'd0;
			drop_avg_q   <= 17'd0;
			idx_q        <= '0;
			which_q      <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (op == OP_EMIT) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (op)
				OP_CLR_INIT: begin
					count_q      <= 32'd0;
					sum_q        <= 64'd0;
					last_time_q  <= 64'd0;
					last_proc_q  <= 64'd0;
					last_drops_q <= 64'd0;
					have_base_q  <= 1'b0;
					have_fps_q   <= 1'b0;
					have_drop_q  <= 1'b0;
					fps_avg_q    <= 32'd0;
					drop_avg_q   <= 17'd0;
					idx_q        <= '0;
				end
				OP_CLR: idx_q <= idx_q + BW'(1);
				OP_REC_WR: begin
					if (count_q != 32'hFFFF_FFFF) count_q <= count_q + 32'd1;
					sum_q <= sum_ext[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_ext[63:0];
				end
				OP_SNP_CHK: begin
					last_time_q  <= t_q;
					last_proc_q  <= proc_q;
					last_drops_q <= drops_q;
					have_base_q  <= 1'b1;
					which_q      <= 1'b0;
				end
				OP_AVG_NEXT: which_q <= 1'b1;
				OP_AVG_INST: begin
					if (!have_sel) begin
						if (which_q) begin
							drop_avg_q  <= inst_n[16:0];
							have_drop_q <= 1'b1;
						end else begin
							fps_avg_q  <= inst_n;
							have_fps_q <= 1'b1;
						end
					end
				end
				OP_AVG_B4: begin
					if (which_q) drop_avg_q <= blend_sum[32:16];
					else fps_avg_q <= blend_sum[47:16];
				end
				OP_WALK_INIT: idx_q <= '0;
				OP_WALK_ACC: if (!walk_hit) idx_q <= idx_q + BW'(1);
				default: ;
			endcase
		end
	end

	// working registers and result word
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		case (op)
			OP_LOAD: begin
				req_q   <= req_type;
				lat_q   <= latency_us;
				t_q     <= timestamp_us;
				proc_q  <= processed_total;
				drops_q <= drops_total;
			end
			OP_REC_RD: bin_q <= bin_n;
			OP_SNP_CHK: begin
				gate_q <= have_base_q && (t_q > last_time_q);
				dt_q   <= t_q - last_time_q;
				dp_q   <= proc_q - last_proc_q;
				dd_q   <= drops_q - last_drops_q;
				mean_q <= 23'd0;
				p95_q  <= 32'd0;
			end
			OP_SNP_RES:  res_q <= dp_q + dd_q;
			OP_AVG_M2:   acc_q <= {32'd0, mul_q};
			OP_AVG_M3:   acc_q <= acc_q + {mul_q, 32'd0};
			OP_AVG_DIV:  sat_q <= acc_q[95:32] >= den_sel;
			OP_AVG_INST: inst_q <= inst_n;
			OP_AVG_B2:   acc_q <= {32'd0, mul_q};
			OP_AVG_B3:   acc_q <= acc_q + {32'd0, mul_q};
			OP_TGT_M:    tgt_q <= tgt_n;
			OP_WALK_INIT: begin
				mean_q <= (dvd_q > 64'(MEAN_MAX)) ? MEAN_MAX : dvd_q[22:0];
				cum_q  <= '0;
			end
			OP_WALK_ACC: cum_q <= cum_n;
			OP_P95:      p95_q <= mul_q[32:1];
			OP_EMIT: begin
				fps_q8            <= fps_avg_q;
				drop_fraction_q16 <= drop_avg_q;
				latency_mean_us   <= mean_q;
				latency_p95_us    <= p95_q;
				latency_valid     <= count_q != 32'd0;
			end
			default: ;
		endcase
	end

	// status to the controller
	assign st.req      = req_q;
	assign st.div_busy = cnt_q != 7'd0;
	assign st.gate     = gate_q;
	assign st.res_nz   = res_q != 64'd0;
	assign st.which    = which_q;
	assign st.have_sel = have_sel;
	assign st.cnt_nz   = count_q != 32'd0;
	assign st.walk_hit = walk_hit;
	assign st.clr_last = idx_q == LAST;
	assign st.out_free = !out_valid || out_ready;
endmodule
`default_nettype wire

>>> rtl/latency_histogram_rate_monitor_top.sv
// Top level of the latency histogram and rate monitor: ports, registers, assertions.
`timescale 1ns / 1ps
`default_nettype none
// Takes one word at a time. A record word runs a 24-step serial division
// by the bucket width, then a read-modify-write of the histogram RAM; a
// clear word sweeps the histogram RAM, one RAM row a cycle. A snapshot
// word works through these steps: each of the two averages needs a 32-step
// division between its multiply steps and its blend steps, the percentile
// target is a single shift-and-add step, the mean takes 64 divider steps,
// and the histogram walk reads one bucket at a time, each in a read state
// and an accumulate state, until the 95th percentile is reached. The single
// shared divider and multiplier serialize these steps; a snapshot also
// waits while an earlier result is still held in the output register.
// After reset the histogram RAM is swept to zero, during which no word is
// taken; register writes are accepted throughout.
// A finished result waits in the output register while the next word is taken.
module latency_histogram_rate_monitor_top #(
	parameter int BUCKETS = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// latency_us[23:0], timestamp_us[87:24], processed_total[151:88], drops_total[215:152]
	input  wire logic [215:0] s_tdata,
	// req_type[1:0]
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// fps_q8[31:0], drop_fraction_q16[48:32], latency_mean_us[71:49], latency_p95_us[103:72]
	output logic [103:0]      m_tdata,
	// latency_valid[0]
	output logic [0:0]        m_tuser,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import lhrm_pkg::*;

	logic [19:0] width_q;
	logic [16:0] alpha_q;
	dp_op_t      op;
	dp_status_t  st;
	logic        cfg_wr;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			alpha_q <= ALPHA_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_BUCKET_WIDTH) width_q <= pwdata[19:0];
			else alpha_q <= pwdata[16:0];
		end
	end

	assign prdata = (paddr[2] == REG_EMA_ALPHA) ? {15'd0, alpha_q} : {12'd0, width_q};

	lhrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.op       (op)
	);

	lhrm_dp #(.BUCKETS(BUCKETS)) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.op                (op),
		.st                (st),
		.bucket_width_us   (width_q),
		.ema_alpha_q16     (alpha_q),
		.req_type          (s_tuser),
		.latency_us        (s_tdata[23:0]),
		.timestamp_us      (s_tdata[87:24]),
		.processed_total   (s_tdata[151:88]),
		.drops_total       (s_tdata[215:152]),
		.out_ready         (m_tready),
		.out_valid         (m_tvalid),
		.fps_q8            (m_tdata[31:0]),
		.drop_fraction_q16 (m_tdata[48:32]),
		.latency_mean_us   (m_tdata[71:49]),
		.latency_p95_us    (m_tdata[103:72]),
		.latency_valid     (m_tuser[0])
	);

	// a result only appears after the emit step
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(op == OP_EMIT))
		else $error("result word without emit step");

	// the divider is never reloaded mid-run
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_REC_DIV || op == OP_AVG_DIV || op == OP_MEAN_DIV)
		|-> !st.div_busy)
		else $error("divider started while busy");

	// no new word is taken while a division is still running
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !st.div_busy)
		else $error("input ready during division");
endmodule
`default_nettype wire
